>>> design/i2cm_pkg.sv
// Types and constants shared by the I2C register access master.
`default_nettype none

package i2cm_pkg;

  localparam logic [7:0] MSB_MASK = 8'h80;

  // a NACK clears the transaction kind; the done tick reports failure on it
  localparam logic [1:0] KIND_FAILED = 2'd0;

  typedef enum logic [1:0] {
    MODE_TICK  = 2'd0,
    MODE_WRITE = 2'd1,
    MODE_READ  = 2'd2,
    MODE_RONLY = 2'd3
  } mode_t;

  // Write groups run bit with SCL low, bit with SCL high, ack with SCL low, ack with SCL high, in four codes each.
  typedef enum logic [4:0] {
    PH_IDLE    = 5'd0,
    PH_ST_A    = 5'd1,
    PH_ST_B    = 5'd2,
    PH_RS_A    = 5'd3,
    PH_RS_B    = 5'd4,
    PH_AW_BIT  = 5'd5,
    PH_AW_LOW  = 5'd6,
    PH_AW_ACKH = 5'd7,
    PH_AW_ACKL = 5'd8,
    PH_RG_BIT  = 5'd9,
    PH_RG_LOW  = 5'd10,
    PH_RG_ACKH = 5'd11,
    PH_RG_ACKL = 5'd12,
    PH_DT_BIT  = 5'd13,
    PH_DT_LOW  = 5'd14,
    PH_DT_ACKH = 5'd15,
    PH_DT_ACKL = 5'd16,
    PH_AR_BIT  = 5'd17,
    PH_AR_LOW  = 5'd18,
    PH_AR_ACKH = 5'd19,
    PH_AR_ACKL = 5'd20,
    PH_RB_PREP = 5'd21,
    PH_RB_HIGH = 5'd22,
    PH_RB_LOW  = 5'd23,
    PH_RA_LOW  = 5'd24,
    PH_RA_HIGH = 5'd25,
    PH_SP_A    = 5'd26,
    PH_SP_B    = 5'd27,
    PH_SP_C    = 5'd28
  } phase_t;

  typedef struct packed {
    phase_t     phase;
    logic [3:0] bit_counter;
    logic [7:0] shift_byte;
    logic [7:0] bytes_left;
    logic [1:0] transaction_kind;
    logic [6:0] saved_device;
    logic [7:0] saved_register;
    logic [7:0] saved_value;
    logic [1:0] line_levels;   // bit0 SCL low, bit1 SDA low
  } i2cm_state_t;

  typedef struct packed {
    mode_t      mode;
    logic [6:0] dev_address;
    logic [7:0] reg_index;
    logic [7:0] write_value;
    logic [7:0] read_count;
    logic       sda_sample;
  } i2cm_cmd_t;

  typedef struct packed {
    logic       scl_pull_low;
    logic       sda_pull_low;
    logic [7:0] read_byte;
    logic       read_valid;
    logic       read_last;
    logic       done_res;
    logic       status;
    logic       busy_res;
  } i2cm_result_t;

endpackage

`default_nettype wire

>>> design/i2cm_step.sv
// Next-state and result logic for one word of the I2C master.
`default_nettype none

module i2cm_step
  import i2cm_pkg::*;
(
  input  i2cm_state_t  cur,
  input  i2cm_cmd_t    cmd,
  output i2cm_state_t  nxt,
  output i2cm_result_t res
);

  logic [4:0] pv;
  logic [1:0] off;
  logic [4:0] base;
  logic       in_group;
  logic       bit_low;
  logic [3:0] bc_inc;
  logic [7:0] sh_in;
  logic [7:0] bl_dec;
  logic       scl;
  logic       sda;

  assign pv       = cur.phase;
  assign off      = 2'(pv - 5'd1);
  assign base     = pv - {3'b000, off};
  assign in_group = (pv >= 5'(PH_AW_BIT)) && (pv < 5'(PH_RB_PREP));
  assign bit_low  = ((cur.shift_byte & MSB_MASK) == 8'h00);
  assign bc_inc   = cur.bit_counter + 4'd1;
  assign sh_in    = {cur.shift_byte[6:0], cmd.sda_sample};
  assign bl_dec   = cur.bytes_left - 8'd1;

  always_comb begin
    nxt = cur;
    res = '0;
    scl = 1'b0;
    sda = 1'b0;
    if (cur.phase == PH_IDLE) begin
      if (cmd.mode != MODE_TICK) begin
        nxt.saved_device     = cmd.dev_address;
        nxt.saved_register   = cmd.reg_index;
        nxt.saved_value      = cmd.write_value;
        nxt.bytes_left       = cmd.read_count;
        nxt.transaction_kind = cmd.mode;
        nxt.bit_counter      = 4'd0;
        nxt.shift_byte       = 8'h00;
        nxt.phase            = PH_ST_A;
      end
      nxt.line_levels = 2'b00;
    end else if (cmd.mode != MODE_TICK) begin
      // Command while busy: repeat the last interval, advance nothing.
      scl = cur.line_levels[0];
      sda = cur.line_levels[1];
    end else begin
      if (in_group) begin
        case (off)
          2'd0: begin
            scl = 1'b1;
            sda = bit_low;
            nxt.phase = phase_t'(base + 5'd1);
          end
          2'd1: begin
            sda = bit_low;
            nxt.shift_byte  = {cur.shift_byte[6:0], 1'b0};
            nxt.bit_counter = bc_inc;
            nxt.phase = (bc_inc >= 4'd8) ? phase_t'(base + 5'd2) : phase_t'(base);
          end
          2'd2: begin
            scl = 1'b1;
            nxt.phase = phase_t'(base + 5'd3);
          end
          default: begin
            if (cmd.sda_sample) begin
              // NACK: mark failure and stop
              nxt.transaction_kind = KIND_FAILED;
              nxt.phase = PH_SP_A;
            end else if (base == 5'(PH_AW_BIT)) begin
              nxt.shift_byte  = cur.saved_register;
              nxt.bit_counter = 4'd0;
              nxt.phase       = PH_RG_BIT;
            end else if (base == 5'(PH_RG_BIT)) begin
              if (cur.transaction_kind == 2'(MODE_WRITE)) begin
                nxt.shift_byte  = cur.saved_value;
                nxt.bit_counter = 4'd0;
                nxt.phase       = PH_DT_BIT;
              end else begin
                nxt.phase = PH_RS_A;
              end
            end else if (base == 5'(PH_DT_BIT)) begin
              nxt.phase = PH_SP_A;
            end else begin
              nxt.phase = (cur.bytes_left != 8'd0) ? PH_RB_PREP : PH_SP_A;
            end
          end
        endcase
      end else begin
        unique case (cur.phase)
          PH_ST_A: nxt.phase = PH_ST_B;
          PH_ST_B: begin
            sda = 1'b1;
            nxt.bit_counter = 4'd0;
            if (cur.transaction_kind == 2'(MODE_RONLY)) begin
              nxt.shift_byte = {cur.saved_device, 1'b1};
              nxt.phase      = PH_AR_BIT;
            end else begin
              nxt.shift_byte = {cur.saved_device, 1'b0};
              nxt.phase      = PH_AW_BIT;
            end
          end
          PH_RS_A: nxt.phase = PH_RS_B;
          PH_RS_B: begin
            sda = 1'b1;
            nxt.bit_counter = 4'd0;
            nxt.shift_byte  = {cur.saved_device, 1'b1};
            nxt.phase       = PH_AR_BIT;
          end
          PH_RB_PREP: begin
            scl = 1'b1;
            nxt.bit_counter = 4'd0;
            nxt.shift_byte  = 8'h00;
            nxt.phase       = PH_RB_HIGH;
          end
          PH_RB_HIGH: begin
            nxt.shift_byte  = sh_in;
            nxt.bit_counter = bc_inc;
            if (bc_inc >= 4'd8) begin
              res.read_valid = 1'b1;
              res.read_byte  = sh_in;
              res.read_last  = (cur.bytes_left == 8'd1);
            end
            nxt.phase = PH_RB_LOW;
          end
          PH_RB_LOW: begin
            scl = 1'b1;
            nxt.phase = (cur.bit_counter >= 4'd8) ? PH_RA_LOW : PH_RB_HIGH;
          end
          PH_RA_LOW: begin
            scl = 1'b1;
            sda = (cur.bytes_left > 8'd1);
            nxt.phase = PH_RA_HIGH;
          end
          PH_RA_HIGH: begin
            sda = (cur.bytes_left > 8'd1);
            nxt.bytes_left = bl_dec;
            nxt.phase = (bl_dec != 8'd0) ? PH_RB_PREP : PH_SP_A;
          end
          PH_SP_A: begin
            scl = 1'b1;
            sda = 1'b1;
            nxt.phase = PH_SP_B;
          end
          PH_SP_B: begin
            sda = 1'b1;
            nxt.phase = PH_SP_C;
          end
          PH_SP_C: begin
            res.done_res = 1'b1;
            res.status   = (cur.transaction_kind == KIND_FAILED);
            nxt.phase    = PH_IDLE;
          end
          default: nxt.phase = PH_IDLE;
        endcase
      end
      nxt.line_levels = {sda, scl};
    end
    res.scl_pull_low = scl;
    res.sda_pull_low = sda;
    res.busy_res     = (nxt.phase != PH_IDLE);
  end

endmodule

`default_nettype wire

>>> design/i2c_master_register_access_unit.sv
// Top level of the I2C register access master with its result register.
// Usage:
//   The input channel carries one word per bus delay interval. in_tuser is
//   the mode: a tick (one interval) or a command (register write, register
//   read with repeated start, read-only). A command taken while idle latches
//   the operands in in_tdata and starts a transaction; one taken while busy
//   is dropped and the last line levels are repeated.
//   Every accepted word gives exactly one result word: the SCL and SDA drive
//   levels for the interval, a received byte with its valid flag (out_tlast
//   marks the final byte), and the done, status and busy flags.
//   out_tvalid rises in the cycle after acceptance. Throughput is one word
//   per cycle while the receiver does not stall; the state step is a single
//   pass of logic between the state register and the result register.
//   When the receiver stalls, the result register holds and in_tready drops
//   until it is taken; in_tready stays high in a cycle where it is taken.
//   Synchronous reset (rst_n low) returns the controller to idle with both
//   lines released and empties the result register.
`default_nettype none

module i2c_master_register_access_unit
  import i2cm_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // [6:0] dev_address, [14:7] reg_index, [22:15] write_value,
  // [30:23] read_count, [31] sda_sample
  input  wire logic [31:0] in_tdata,
  // [1:0] mode
  input  wire logic [1:0]  in_tuser,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // [0] scl_pull_low, [1] sda_pull_low, [9:2] read_byte, [10] read_valid,
  // [11] done_res, [12] status, [13] busy_res, [15:14] zero
  output logic [15:0]      out_tdata,
  // read_last
  output logic             out_tlast
);

  i2cm_state_t  state_r;
  i2cm_state_t  state_nxt;
  i2cm_cmd_t    cmd;
  i2cm_result_t res;
  logic         out_valid_r;
  logic [15:0]  out_data_r;
  logic         out_last_r;
  logic         in_fire;

  assign in_tready = !out_valid_r || out_tready;
  assign in_fire   = in_tvalid && in_tready;

  assign cmd.mode        = mode_t'(in_tuser);
  assign cmd.dev_address = in_tdata[6:0];
  assign cmd.reg_index   = in_tdata[14:7];
  assign cmd.write_value = in_tdata[22:15];
  assign cmd.read_count  = in_tdata[30:23];
  assign cmd.sda_sample  = in_tdata[31];

  i2cm_step u_step (
    .cur (state_r),
    .cmd (cmd),
    .nxt (state_nxt),
    .res (res)
  );

  // all-zero state is idle with both lines released
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (in_fire) begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  // hold the word while stalled, load a fresh one on acceptance
  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_data_r <= {2'b00, res.busy_res, res.status, res.done_res, res.read_valid,
                     res.read_byte, res.sda_pull_low, res.scl_pull_low};
      out_last_r <= res.read_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

`ifndef SYNTHESIS
  a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tdata[11] && out_tdata[13]))
    else $error("done and busy reported together");

  a_status_with_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[12]) |-> out_tdata[11])
    else $error("status set without done");

  a_read_lines: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[10]) |-> (out_tdata[1:0] == 2'b00))
    else $error("read byte completed while a line is driven");

  a_last_with_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tlast) |-> out_tdata[10])
    else $error("last flag without a read byte");

  a_cmd_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && state_r.phase == PH_IDLE && in_tuser != 2'(MODE_TICK))
      |=> (state_r.phase == PH_ST_A && out_tvalid && out_tdata[13]))
    else $error("command taken while idle did not start a transaction");
`endif

endmodule

`default_nettype wire
